// ===== hdl/shash_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 stream hasher.
package shash_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} shash_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} shash_out_t;

	typedef enum logic [1:0] {
		BSEL_DATA = 2'd0,
		BSEL_PAD  = 2'd1,
		BSEL_LEN  = 2'd2,
		BSEL_ZERO = 2'd3
	} shash_bsel_t;

	typedef struct packed {
		logic        shift_byte;
		shash_bsel_t bsel;
		logic [2:0]  len_idx;
		logic        count;
		logic        round;
		logic [5:0]  rnd;
		logic        fold;
		logic        emit;
		logic        init;
	} shash_cmd_t;

	localparam logic [5:0] LAST_BYTE  = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [5:0] LEN_START  = 6'd56;
	localparam logic [2:0] LAST_WORD  = 3'd7;
	localparam logic [7:0] PAD_BYTE   = 8'h80;

	localparam logic [31:0] SHASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] r);
		case (r)
			6'd0:  round_k = 32'h428a2f98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;
			6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;
			6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;
			6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;
			6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			6'd63: round_k = 32'hc67178f2;
			default: round_k = 32'h0;
		endcase
	endfunction

endpackage

// ===== hdl/shash_dp.sv =====
// Datapath: byte-shifted message window, schedule, round logic, chaining words, length count.
module shash_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  shash_pkg::shash_cmd_t  cmd,
	input  logic [7:0]             data_byte,
	output logic [31:0]            out_word
);
	import shash_pkg::*;

	logic [31:0] win_q   [16];
	logic [31:0] chain_q [8];
	logic [31:0] work_q  [8];
	logic [60:0] total_q;
	logic [31:0] word_q;

	logic [63:0] len_bits;
	logic [7:0]  pbyte;
	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;

	assign len_bits = {total_q, 3'b000};
	assign out_word = word_q;

	always_comb begin
		case (cmd.bsel)
			BSEL_DATA: pbyte = data_byte;
			BSEL_PAD:  pbyte = PAD_BYTE;
			BSEL_LEN:  pbyte = len_bits[8 * (7 - int'(cmd.len_idx)) +: 8];
			default:   pbyte = 8'h00;
		endcase
	end

	assign w_new = small_sig1(win_q[14]) + win_q[9] + small_sig0(win_q[1]) + win_q[0];

	assign t1 = work_q[7] + big_sig1(work_q[4])
		+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
		+ round_k(cmd.rnd) + win_q[0];
	assign t2 = big_sig0(work_q[0])
		+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

	// window: bytes enter at the bottom; during rounds it moves one word per cycle
	always_ff @(posedge clk) begin
		if (cmd.shift_byte) begin
			for (int j = 0; j < 15; j++) begin
				win_q[j] <= {win_q[j][23:0], win_q[j + 1][31:24]};
			end
			win_q[15] <= {win_q[15][23:0], pbyte};
		end else if (cmd.round) begin
			for (int j = 0; j < 15; j++) begin
				win_q[j] <= win_q[j + 1];
			end
			win_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			word_q <= chain_q[0];
		end
	end

	// working words equal the chaining words whenever neither a compression nor the digest output runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= SHASH_IV;
			work_q  <= SHASH_IV;
			total_q <= '0;
		end else begin
			if (cmd.count) begin
				total_q <= total_q + 61'd1;
			end
			if (cmd.init) begin
				chain_q <= SHASH_IV;
				work_q  <= SHASH_IV;
				total_q <= '0;
			end else if (cmd.fold) begin
				for (int j = 0; j < 8; j++) begin
					chain_q[j] <= chain_q[j] + work_q[j];
					work_q[j]  <= chain_q[j] + work_q[j];
				end
			end else if (cmd.round) begin
				work_q[7] <= work_q[6];
				work_q[6] <= work_q[5];
				work_q[5] <= work_q[4];
				work_q[4] <= work_q[3] + t1;
				work_q[3] <= work_q[2];
				work_q[2] <= work_q[1];
				work_q[1] <= work_q[0];
				work_q[0] <= t1 + t2;
			end else if (cmd.emit) begin
				for (int j = 0; j < 7; j++) begin
					chain_q[j] <= chain_q[j + 1];
				end
				chain_q[7] <= chain_q[0];
			end
		end
	end

endmodule

// ===== hdl/shash_ctrl.sv =====
// Controller: fill count, padding sequence, round counter and digest output handshake.
module shash_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   byte_present,
	input  logic                   end_of_message,
	output logic                   item_stall,
	output logic                   digest_valid,
	input  logic                   digest_stall,
	output logic [2:0]             word_index,
	output logic                   last_word,
	output shash_pkg::shash_cmd_t  cmd
);
	import shash_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PAD   = 5'b00010,
		S_ROUND = 5'b00100,
		S_FINAL = 5'b01000,
		S_OUT   = 5'b10000
	} shash_state_t;

	shash_state_t state_q, state_d;
	logic [5:0] fill_q, fill_d;
	logic [5:0] rnd_q, rnd_d;
	logic [2:0] ocnt_q, ocnt_d;
	logic [2:0] oidx_q, oidx_d;
	logic       ovalid_q, ovalid_d;
	logic       msg_end_q, msg_end_d;
	logic       pad_first_q, pad_first_d;
	logic       len_ok_q, len_ok_d;
	logic       len_done_q, len_done_d;
	logic       load_out;

	assign item_stall   = (state_q != S_IDLE);
	assign digest_valid = ovalid_q;
	assign word_index   = oidx_q;
	assign last_word    = (oidx_q == LAST_WORD);
	assign load_out     = (state_q == S_OUT) && (!ovalid_q || !digest_stall);

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		rnd_d       = rnd_q;
		ocnt_d      = ocnt_q;
		oidx_d      = oidx_q;
		ovalid_d    = ovalid_q & digest_stall;
		msg_end_d   = msg_end_q;
		pad_first_d = pad_first_q;
		len_ok_d    = len_ok_q;
		len_done_d  = len_done_q;
		cmd         = '0;
		cmd.bsel    = BSEL_DATA;
		cmd.rnd     = rnd_q;
		cmd.len_idx = fill_q[2:0];
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					if (byte_present) begin
						cmd.shift_byte = 1'b1;
						cmd.count      = 1'b1;
						if (fill_q == LAST_BYTE) begin
							fill_d  = '0;
							rnd_d   = '0;
							state_d = S_ROUND;
							if (end_of_message) begin
								msg_end_d   = 1'b1;
								pad_first_d = 1'b1;
								len_ok_d    = 1'b1;
							end
						end else begin
							fill_d = fill_q + 6'd1;
							if (end_of_message) begin
								state_d     = S_PAD;
								pad_first_d = 1'b1;
								len_ok_d    = (fill_q + 6'd1) < LEN_START;
							end
						end
					end else if (end_of_message) begin
						state_d     = S_PAD;
						pad_first_d = 1'b1;
						len_ok_d    = fill_q < LEN_START;
					end
				end
			end
			S_PAD: begin
				cmd.shift_byte = 1'b1;
				if (pad_first_q) begin
					cmd.bsel = BSEL_PAD;
				end else if (len_ok_q && fill_q >= LEN_START) begin
					cmd.bsel = BSEL_LEN;
				end else begin
					cmd.bsel = BSEL_ZERO;
				end
				pad_first_d = 1'b0;
				if (fill_q == LAST_BYTE) begin
					fill_d     = '0;
					len_done_d = len_ok_q;
					len_ok_d   = 1'b1;
					msg_end_d  = 1'b1;
					rnd_d      = '0;
					state_d    = S_ROUND;
				end else begin
					fill_d = fill_q + 6'd1;
				end
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				rnd_d     = rnd_q + 6'd1;
				if (rnd_q == LAST_ROUND) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				cmd.fold = 1'b1;
				if (len_done_q) begin
					ocnt_d  = '0;
					state_d = S_OUT;
				end else if (msg_end_q) begin
					state_d = S_PAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_OUT: begin
				if (load_out) begin
					cmd.emit = 1'b1;
					ovalid_d = 1'b1;
					oidx_d   = ocnt_q;
					ocnt_d   = ocnt_q + 3'd1;
					if (ocnt_q == LAST_WORD) begin
						cmd.init    = 1'b1;
						fill_d      = '0;
						msg_end_d   = 1'b0;
						pad_first_d = 1'b0;
						len_ok_d    = 1'b0;
						len_done_d  = 1'b0;
						state_d     = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			rnd_q       <= '0;
			ocnt_q      <= '0;
			oidx_q      <= '0;
			ovalid_q    <= 1'b0;
			msg_end_q   <= 1'b0;
			pad_first_q <= 1'b0;
			len_ok_q    <= 1'b0;
			len_done_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			rnd_q       <= rnd_d;
			ocnt_q      <= ocnt_d;
			oidx_q      <= oidx_d;
			ovalid_q    <= ovalid_d;
			msg_end_q   <= msg_end_d;
			pad_first_q <= pad_first_d;
			len_ok_q    <= len_ok_d;
			len_done_q  <= len_done_d;
		end
	end

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && rnd_q == LAST_ROUND) |=> (state_q == S_FINAL))
		else $error("compression did not finish after the last round");

	a_len_in_msg: assert property (@(posedge clk) disable iff (!arst_n)
		len_done_q |-> msg_end_q)
		else $error("length block done outside a message end");

	a_out_after_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> len_done_q)
		else $error("digest output without the length block");

	a_fresh_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && ocnt_q == LAST_WORD) |=> (state_q == S_IDLE && fill_q == '0 && !msg_end_q))
		else $error("hasher not back to a fresh message after the digest");

endmodule

// ===== hdl/sha256_stream_hasher_unit.sv =====
// Top level of the SHA-256 stream hasher: controller plus datapath.
// A message byte request is taken while the unit is idle; the request that completes a 64-byte block is
// followed by a busy period (64 rounds at one per cycle and the chaining add). An
// end-of-message request then pads one byte per cycle up to the end of the block, runs
// one or two further compressions, and gives the eight digest words,
// one per cycle while the output is not stalled, index 0 first. After the last word is
// registered the unit takes the next message; the output register lets that happen
// while the final word still waits.
module sha256_stream_hasher_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  shash_pkg::shash_in_t   item,
	output logic                   digest_valid,
	input  logic                   digest_stall,
	output shash_pkg::shash_out_t  digest
);
	import shash_pkg::*;

	shash_cmd_t  cmd;
	logic [31:0] out_word;
	logic [2:0]  word_index;
	logic        last_word;

	shash_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.byte_present   (item.byte_present),
		.end_of_message (item.end_of_message),
		.item_stall     (item_stall),
		.digest_valid   (digest_valid),
		.digest_stall   (digest_stall),
		.word_index     (word_index),
		.last_word      (last_word),
		.cmd            (cmd)
	);

	shash_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (item.data_byte),
		.out_word  (out_word)
	);

	assign digest.digest_word = out_word;
	assign digest.word_index  = word_index;
	assign digest.last_word   = last_word;

endmodule
